[sv/serial_command_line_parser_core_defines.svh]
// Assertion macros shared by the parser RTL.
`ifndef SERIAL_COMMAND_LINE_PARSER_CORE_DEFINES_SVH
`define SERIAL_COMMAND_LINE_PARSER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SCL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SCL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SCL_ASSERT_SAME(label, ante, cons, msg)
`define SCL_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

[sv/scl_pkg.sv]
package scl_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int EXT_WIDTH   = VALUE_WIDTH + 4;

    localparam logic [VALUE_WIDTH-1:0] MAG_LIMIT   = VALUE_WIDTH'(1) << (VALUE_WIDTH - 1);
    localparam logic [VALUE_WIDTH-1:0] POS_MAXIMUM = MAG_LIMIT - VALUE_WIDTH'(1);

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_RETURN  = 8'h0D;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_VTAB    = 8'h0B;
    localparam logic [7:0] CH_FFEED   = 8'h0C;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    typedef enum logic [1:0] {
        PH_SIGN   = 2'd0,
        PH_DIGITS = 2'd1,
        PH_FROZEN = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        FIELD_CMD    = 2'd0,
        FIELD_FIRST  = 2'd1,
        FIELD_SECOND = 2'd2
    } field_pos_t;

    typedef struct packed {
        logic feed;
        logic clear;
    } arg_ctrl_t;

endpackage

[sv/scl_arg.sv]
`include "serial_command_line_parser_core_defines.svh"

module scl_arg
    import scl_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  arg_ctrl_t                     ctrl,
    input  logic [7:0]                    data_byte,
    output logic signed [VALUE_WIDTH-1:0] value
);

    logic [VALUE_WIDTH-1:0] accum_reg;
    logic [VALUE_WIDTH-1:0] accum_next;
    phase_t                 phase_reg;
    phase_t                 phase_next;
    logic                   negative_reg;
    logic                   negative_next;

    logic                   is_digit;
    logic                   is_blank;
    logic [EXT_WIDTH-1:0]   acc_ext;
    logic [EXT_WIDTH-1:0]   product;
    logic [VALUE_WIDTH-1:0] accum_step;

    assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
    assign is_blank = (data_byte == CH_TAB) || (data_byte == CH_VTAB) || (data_byte == CH_FFEED);

    // Times ten as two shifts, plus the digit taken from the low nibble.
    assign acc_ext    = EXT_WIDTH'(accum_reg);
    assign product    = (acc_ext << 3) + (acc_ext << 1) + EXT_WIDTH'(data_byte[3:0]);
    assign accum_step = (product > EXT_WIDTH'(MAG_LIMIT)) ? MAG_LIMIT
                                                          : product[VALUE_WIDTH-1:0];

    always_comb
    begin
        accum_next    = accum_reg;
        phase_next    = phase_reg;
        negative_next = negative_reg;
        if (ctrl.clear)
        begin
            accum_next    = '0;
            phase_next    = PH_SIGN;
            negative_next = 1'b0;
        end
        else if (ctrl.feed)
        begin
            unique case (phase_reg)
                PH_SIGN:
                begin
                    if (is_blank)
                    begin
                        phase_next = PH_SIGN;
                    end
                    else if ((data_byte == CH_PLUS) || (data_byte == CH_MINUS))
                    begin
                        negative_next = (data_byte == CH_MINUS);
                        phase_next    = PH_DIGITS;
                    end
                    else if (!is_digit)
                    begin
                        phase_next = PH_FROZEN;
                    end
                    else
                    begin
                        phase_next = PH_DIGITS;
                        accum_next = accum_step;
                    end
                end
                PH_DIGITS:
                begin
                    if (is_digit)
                    begin
                        accum_next = accum_step;
                    end
                    else
                    begin
                        phase_next = PH_FROZEN;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg    <= '0;
            phase_reg    <= PH_SIGN;
            negative_reg <= 1'b0;
        end
        else
        begin
            accum_reg    <= accum_next;
            phase_reg    <= phase_next;
            negative_reg <= negative_next;
        end
    end

    always_comb
    begin
        if (negative_reg)
        begin
            value = VALUE_WIDTH'(-accum_reg);
        end
        else if (accum_reg > POS_MAXIMUM)
        begin
            value = POS_MAXIMUM;
        end
        else
        begin
            value = accum_reg;
        end
    end

    `SCL_ASSERT_SAME(a_accum_capped, 1'b1, accum_reg <= MAG_LIMIT, "magnitude above limit")
    `SCL_ASSERT_NEXT(a_frozen_holds, (phase_reg == PH_FROZEN) && !ctrl.clear,
                     (phase_reg == PH_FROZEN) && $stable(accum_reg), "frozen argument changed")
    `SCL_ASSERT_NEXT(a_clear_resets, ctrl.clear,
                     (accum_reg == '0) && (phase_reg == PH_SIGN) && !negative_reg,
                     "argument not cleared")

endmodule

[sv/serial_command_line_parser_core.sv]
// A terminator passes the input register and then the result register, where its result
// is held with out_valid high until a rising edge with out_stall low takes it.
// Throughput: one byte per cycle while in_stall is low; the input register and
// the result register let a byte be taken while a finished result still waits on out_stall.
// A terminator stalls in the input register only while the result register is full and stalled.
// Reset (rst_n low, asynchronous) clears both valid flags, the field position,
// the command letter and both argument accumulators.
`include "serial_command_line_parser_core_defines.svh"

module serial_command_line_parser_core
    import scl_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    data_byte,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [7:0]                    command_char,
    output logic signed [VALUE_WIDTH-1:0] first_value,
    output logic signed [VALUE_WIDTH-1:0] second_value,
    output logic [1:0]                    fields_seen
);

    logic                          in_valid_reg;
    logic [7:0]                    in_byte_reg;
    logic                          in_accept;
    logic                          out_free;
    logic                          proc_en;
    logic                          is_term;
    logic                          is_space;

    field_pos_t                    field_pos_reg;
    field_pos_t                    field_pos_next;
    logic [7:0]                    command_reg;
    logic [7:0]                    command_next;

    arg_ctrl_t                     first_ctrl;
    arg_ctrl_t                     second_ctrl;
    logic signed [VALUE_WIDTH-1:0] first_val;
    logic signed [VALUE_WIDTH-1:0] second_val;

    logic                          out_valid_reg;
    logic [7:0]                    command_char_reg;
    logic signed [VALUE_WIDTH-1:0] first_value_reg;
    logic signed [VALUE_WIDTH-1:0] second_value_reg;
    logic [1:0]                    fields_seen_reg;

    assign is_term  = (in_byte_reg == CH_NEWLINE) || (in_byte_reg == CH_RETURN)
                   || (in_byte_reg == CH_SLASH);
    assign is_space = (in_byte_reg == CH_SPACE);
    assign out_free = !out_valid_reg || !out_stall;
    assign proc_en  = in_valid_reg && (!is_term || out_free);
    assign in_stall = in_valid_reg && !proc_en;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (proc_en)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_byte_reg <= data_byte;
        end
    end

    always_comb
    begin
        field_pos_next = field_pos_reg;
        command_next   = command_reg;
        if (proc_en)
        begin
            if (is_term)
            begin
                field_pos_next = FIELD_CMD;
                command_next   = '0;
            end
            else if (is_space)
            begin
                unique case (field_pos_reg)
                    FIELD_CMD:    field_pos_next = FIELD_FIRST;
                    FIELD_FIRST:  field_pos_next = FIELD_SECOND;
                    default:      field_pos_next = FIELD_SECOND;
                endcase
            end
            else if (field_pos_reg == FIELD_CMD)
            begin
                command_next = in_byte_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_pos_reg <= FIELD_CMD;
            command_reg   <= '0;
        end
        else
        begin
            field_pos_reg <= field_pos_next;
            command_reg   <= command_next;
        end
    end

    assign first_ctrl.feed   = proc_en && !is_term && !is_space && (field_pos_reg == FIELD_FIRST);
    assign first_ctrl.clear  = proc_en && is_term;
    assign second_ctrl.feed  = proc_en && !is_term && !is_space && (field_pos_reg == FIELD_SECOND);
    assign second_ctrl.clear = proc_en && is_term;

    scl_arg u_first_arg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (first_ctrl),
        .data_byte (in_byte_reg),
        .value     (first_val)
    );

    scl_arg u_second_arg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (second_ctrl),
        .data_byte (in_byte_reg),
        .value     (second_val)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (proc_en && is_term)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_en && is_term)
        begin
            command_char_reg <= command_reg;
            first_value_reg  <= first_val;
            second_value_reg <= second_val;
            fields_seen_reg  <= field_pos_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign command_char = command_char_reg;
    assign first_value  = first_value_reg;
    assign second_value = second_value_reg;
    assign fields_seen  = fields_seen_reg;

    `SCL_ASSERT_SAME(a_stall_needs_item, in_stall, in_valid_reg && is_term && out_valid_reg,
                     "input stalled without a blocked terminator")
    `SCL_ASSERT_NEXT(a_term_gives_result, proc_en && is_term,
                     out_valid_reg && (field_pos_reg == FIELD_CMD) && (command_reg == '0),
                     "terminator did not produce a result and clear the line")
    `SCL_ASSERT_SAME(a_fields_range, out_valid_reg, fields_seen_reg != 2'd3,
                     "field count out of range")
    `SCL_ASSERT_NEXT(a_pos_only_on_space, proc_en && !is_term && !is_space,
                     $stable(field_pos_reg), "field position moved without a space")

endmodule
